/* hdl/grts_pkg.sv */
package grts_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ROTATE = 2'd1,
    KIND_TEST   = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEG,
    ST_EXEC,
    ST_SORT,
    ST_PAIR,
    ST_SCAN,
    ST_DONE
  } state_e;

  localparam logic [5:0] VCOUNT_RESET = 6'd32;

endpackage

/* hdl/graph_rotation_triple_search_top.sv */
// Channel      Direction  Handshake                Payload
// in           input      in_valid_i/in_stall_o    kind, first/middle/last vertex, edge value
// out          output     out_valid_o/out_stall_i  flags and found triple
// cfg          input      cfg_valid_i/cfg_ready_o  vertex_count
//
// Each transaction is worked on alone. Degrees are recounted one row per cycle
// over all MAX_VERTICES stored rows before every item, then the execute state
// and the finish state follow, and the result is offered from the output
// register. A search ranks the vertices by a selection pass between those two
// states, which checks every vertex for each rank, and scans candidate pairs,
// one row comparison per cycle (at most N*(N-1)/2 pairs), up to the first hit.
// Reset clears the adjacency rows and the control registers asynchronously;
// the data path registers are loaded before they are read.
// The result waits in an output register while out_stall_i is high, and the
// next input is taken in the cycle after the result has been taken.
module graph_rotation_triple_search_top #(
  parameter int MAX_VERTICES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [4:0] first_vertex_i,
  input  logic [4:0] middle_vertex_i,
  input  logic [4:0] last_vertex_i,
  input  logic       edge_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_increasing_o,
  output logic       is_decreasing_o,
  output logic       found_o,
  output logic [4:0] found_x_o,
  output logic [4:0] found_v_o,
  output logic [4:0] found_y_o,
  output logic       index_error_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_vertex_count_i
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = CW;

  logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
  logic [DW-1:0]           deg_q [MAX_VERTICES];
  logic [IW-1:0]           ord_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] taken_q;

  grts_pkg::state_e state_q, state_d;
  logic [5:0]  vcount_q;
  logic [CW-1:0] n_w;
  logic [MAX_VERTICES-1:0] cmask_w;

  logic [1:0]  kind_q;
  logic [4:0]  x_q, v_q, y_q;
  logic        val_q;
  logic [CW-1:0] cnt_q;      // row counter / rank counter
  logic [CW-1:0] scan_q;     // candidate index within a rank pass
  logic [IW-1:0] best_q;
  logic [DW-1:0] bestd_q;
  logic        best_ok_q;
  logic [CW-1:0] i_q, j_q;   // positions in the degree order

  logic        ov_q, inc_q, dec_q, fnd_q, err_q;
  logic [4:0]  fx_q, fv_q, fy_q;

  logic [IW-1:0] xi_w, vi_w, yi_w;
  assign xi_w = IW'(x_q);
  assign vi_w = IW'(v_q);
  assign yi_w = IW'(y_q);

  // Number of vertices in use, clipped to the storage size.
  always_comb begin
    if ({26'd0, vcount_q} > MAX_VERTICES) n_w = CW'(MAX_VERTICES);
    else n_w = CW'(vcount_q);
    for (int k = 0; k < MAX_VERTICES; k++) cmask_w[k] = (k < n_w);
  end

  function automatic logic [CW-1:0] popcnt(input logic [MAX_VERTICES-1:0] w);
    logic [CW-1:0] c;
    c = '0;
    for (int k = 0; k < MAX_VERTICES; k++) c = c + CW'(w[k]);
    return c;
  endfunction

  logic ix_ok, iv_ok, iy_ok, bad_idx;
  assign ix_ok = (7'(x_q) < 7'(n_w));
  assign iv_ok = (7'(v_q) < 7'(n_w));
  assign iy_ok = (7'(y_q) < 7'(n_w));
  always_comb begin
    unique case (grts_pkg::kind_e'(kind_q))
      grts_pkg::KIND_LOAD:   bad_idx = !ix_ok || !iy_ok;
      grts_pkg::KIND_SEARCH: bad_idx = 1'b0;
      default:               bad_idx = !ix_ok || !iv_ok || !iy_ok;
    endcase
  end

  // Shared row comparison for the scan: x row and y row.
  logic [IW-1:0] sx_w, sy_w;
  logic [MAX_VERTICES-1:0] hit_w;
  logic [IW-1:0] hit_idx_w;
  logic          hit_any_w;
  assign sy_w = ord_q[i_q[IW-1:0]];
  assign sx_w = ord_q[j_q[IW-1:0]];
  always_comb begin
    hit_w = adj_q[sx_w] & ~adj_q[sy_w] & cmask_w;
    hit_w[sx_w] = 1'b0;
    hit_w[sy_w] = 1'b0;
    hit_any_w = |hit_w;
    hit_idx_w = '0;
    for (int k = MAX_VERTICES - 1; k >= 0; k--) if (hit_w[k]) hit_idx_w = IW'(k);
  end

  // Selection candidate for the sort pass.
  logic [IW-1:0] cand_w;
  logic          cand_better_w;
  assign cand_w = scan_q[IW-1:0];
  assign cand_better_w = !taken_q[cand_w] && (!best_ok_q || deg_q[cand_w] > bestd_q);

  assign in_stall_o  = (state_q != grts_pkg::ST_IDLE) || ov_q;
  assign cfg_ready_o = (state_q == grts_pkg::ST_IDLE) && !ov_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grts_pkg::ST_IDLE: if (in_valid_i && !in_stall_o) state_d = grts_pkg::ST_DEG;
      grts_pkg::ST_DEG:  if (cnt_q == CW'(MAX_VERTICES - 1)) state_d = grts_pkg::ST_EXEC;
      grts_pkg::ST_EXEC: begin
        if (bad_idx || kind_q != grts_pkg::KIND_SEARCH) state_d = grts_pkg::ST_DONE;
        else if (n_w < CW'(2)) state_d = grts_pkg::ST_DONE;
        else state_d = grts_pkg::ST_SORT;
      end
      grts_pkg::ST_SORT: if (scan_q == n_w - 1'b1 && cnt_q == n_w - 1'b1)
        state_d = grts_pkg::ST_PAIR;
      grts_pkg::ST_PAIR: begin
        if (hit_any_w) state_d = grts_pkg::ST_DONE;
        else if (j_q == i_q + 1'b1 && i_q + CW'(2) >= n_w) state_d = grts_pkg::ST_DONE;
      end
      grts_pkg::ST_DONE: state_d = grts_pkg::ST_IDLE;
      default: state_d = grts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= grts_pkg::ST_IDLE;
      vcount_q <= grts_pkg::VCOUNT_RESET;
      ov_q     <= 1'b0;
      for (int k = 0; k < MAX_VERTICES; k++) adj_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) vcount_q <= cfg_vertex_count_i;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (state_q == grts_pkg::ST_DONE) ov_q <= 1'b1;
      if (state_q == grts_pkg::ST_EXEC && !bad_idx) begin
        if (kind_q == grts_pkg::KIND_LOAD) adj_q[xi_w][yi_w] <= val_q;
        if (kind_q == grts_pkg::KIND_ROTATE) begin
          // Clear first, then set: a clear that lands on a bit set afterwards
          // is skipped, and a bit named twice is written once.
          if (x_q != y_q) begin
            adj_q[xi_w][vi_w] <= 1'b0;
            if (x_q != v_q) adj_q[vi_w][xi_w] <= 1'b0;
          end
          adj_q[vi_w][yi_w] <= 1'b1;
          if (v_q != y_q) adj_q[yi_w][vi_w] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      grts_pkg::ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          kind_q <= kind_i;
          x_q <= first_vertex_i;
          v_q <= middle_vertex_i;
          y_q <= last_vertex_i;
          val_q <= edge_value_i;
          cnt_q <= '0;
          inc_q <= 1'b0; dec_q <= 1'b0; fnd_q <= 1'b0; err_q <= 1'b0;
          fx_q <= '0; fv_q <= '0; fy_q <= '0;
        end
      end
      grts_pkg::ST_DEG: begin
        deg_q[cnt_q[IW-1:0]] <= popcnt(adj_q[cnt_q[IW-1:0]] & cmask_w);
        cnt_q <= cnt_q + 1'b1;
      end
      grts_pkg::ST_EXEC: begin
        err_q <= bad_idx;
        if (!bad_idx && kind_q == grts_pkg::KIND_TEST &&
            adj_q[xi_w][vi_w] && !adj_q[yi_w][vi_w]) begin
          inc_q <= deg_q[xi_w] <= deg_q[yi_w];
          dec_q <= {1'b0, deg_q[xi_w]} > {1'b0, deg_q[yi_w]} + 1'b1;
        end
        cnt_q <= '0; scan_q <= '0; best_ok_q <= 1'b0; taken_q <= '0;
        i_q <= '0; j_q <= n_w - 1'b1;
      end
      grts_pkg::ST_SORT: begin
        // Strict compare over ascending index keeps the lowest index on ties.
        if (cand_better_w) begin
          best_q <= cand_w; bestd_q <= deg_q[cand_w]; best_ok_q <= 1'b1;
        end
        if (scan_q == n_w - 1'b1) begin
          ord_q[cnt_q[IW-1:0]] <= cand_better_w ? cand_w : best_q;
          taken_q[cand_better_w ? cand_w : best_q] <= 1'b1;
          cnt_q <= cnt_q + 1'b1; scan_q <= '0; best_ok_q <= 1'b0;
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end
      grts_pkg::ST_PAIR: begin
        if (hit_any_w) begin
          fnd_q <= 1'b1;
          fx_q <= 5'(sx_w); fv_q <= 5'(hit_idx_w); fy_q <= 5'(sy_w);
        end else if (j_q == i_q + 1'b1) begin
          i_q <= i_q + 1'b1; j_q <= n_w - 1'b1;
        end else begin
          j_q <= j_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = ov_q;
  assign is_increasing_o = inc_q;
  assign is_decreasing_o = dec_q;
  assign found_o         = fnd_q;
  assign found_x_o       = fx_q;
  assign found_v_o       = fv_q;
  assign found_y_o       = fy_q;
  assign index_error_o   = err_q;

endmodule

/* tb/graph_rotation_triple_search_checker.sv */
module graph_rotation_triple_search_checker #(
  parameter int MAX_VERTICES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] kind_i,
  input  logic [4:0] first_vertex_i,
  input  logic [4:0] middle_vertex_i,
  input  logic [4:0] last_vertex_i,
  input  logic       edge_value_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       is_increasing_i,
  input  logic       is_decreasing_i,
  input  logic       found_i,
  input  logic [4:0] found_x_i,
  input  logic [4:0] found_v_i,
  input  logic [4:0] found_y_i,
  input  logic       index_error_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [5:0] cfg_vertex_count_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       inc;
    logic       dec;
    logic       found;
    logic [4:0] fx;
    logic [4:0] fv;
    logic [4:0] fy;
    logic       err;
  } verdict_t;

  logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
  int                      degree [MAX_VERTICES];
  logic [5:0]              vcount;
  verdict_t                verdicts_due [$];

  function automatic int active_vertices();
    return (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
  endfunction

  // Degrees only count the columns below the vertex count in use.
  task automatic recount_degrees(input int n);
    logic [MAX_VERTICES:0] mask;
    mask = ({{MAX_VERTICES{1'b0}}, 1'b1} << n) - 1'b1;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      degree[i] = $countones(adj_rows[i] & mask[MAX_VERTICES-1:0]);
    end
  endtask

  task automatic apply_item(input grts_pkg::kind_e kind, input int x, input int v,
                            input int y, input logic val, output verdict_t r);
    int n;
    int order [MAX_VERTICES];
    int j;
    int cur;
    bit hit;
    n = active_vertices();
    r = '0;
    hit = 0;
    recount_degrees(n);
    case (kind)
      grts_pkg::KIND_LOAD: begin
        if (x >= n || y >= n) r.err = 1'b1;
        else adj_rows[x][y] = val;
      end
      grts_pkg::KIND_ROTATE: begin
        if (x >= n || v >= n || y >= n) r.err = 1'b1;
        else begin
          adj_rows[x][v] = 1'b0;
          adj_rows[v][x] = 1'b0;
          adj_rows[v][y] = 1'b1;
          adj_rows[y][v] = 1'b1;
        end
      end
      grts_pkg::KIND_TEST: begin
        if (x >= n || v >= n || y >= n) r.err = 1'b1;
        else if (adj_rows[x][v] && !adj_rows[y][v]) begin
          r.inc = degree[x] <= degree[y];
          r.dec = degree[x] > degree[y] + 1;
        end
      end
      default: begin
        // Stable ranking: highest degree first, equal degrees by ascending index.
        for (int i = 0; i < n; i++) begin
          cur = i;
          j = i;
          while (j > 0 && degree[order[j-1]] < degree[cur]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = cur;
        end
        for (int i = 0; i < n && !hit; i++) begin
          for (int k = n - 1; k > i && !hit; k--) begin
            for (int w = 0; w < n && !hit; w++) begin
              if (w != order[k] && w != order[i] &&
                  adj_rows[order[k]][w] && !adj_rows[order[i]][w]) begin
                hit = 1;
                r.found = 1'b1;
                r.fx = order[k][4:0];
                r.fv = w[4:0];
                r.fy = order[i][4:0];
              end
            end
          end
        end
      end
    endcase
  endtask

  function automatic int compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t r;
    verdict_t e;
    int bad;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
      vcount = grts_pkg::VCOUNT_RESET;
      verdicts_due.delete();
      pending_o = 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) vcount = cfg_vertex_count_i;
      if (in_valid_i && !in_stall_i) begin
        apply_item(grts_pkg::kind_e'(kind_i), int'(first_vertex_i),
                   int'(middle_vertex_i), int'(last_vertex_i), edge_value_i, r);
        verdicts_due.push_back(r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          $error("result transaction arrived with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = verdicts_due.pop_front();
          bad = 0;
          bad += compare_field("is_increasing", int'(e.inc), int'(is_increasing_i));
          bad += compare_field("is_decreasing", int'(e.dec), int'(is_decreasing_i));
          bad += compare_field("found", int'(e.found), int'(found_i));
          bad += compare_field("found_x", int'(e.fx), int'(found_x_i));
          bad += compare_field("found_v", int'(e.fv), int'(found_v_i));
          bad += compare_field("found_y", int'(e.fy), int'(found_y_i));
          bad += compare_field("index_error", int'(e.err), int'(index_error_i));
          if (bad != 0) fail_count_o <= fail_count_o + 1;
        end
      end
      pending_o = verdicts_due.size();
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit is set far above the slowest expected run, a search at the full
  // vertex count.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 580;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i = grts_pkg::KIND_LOAD;
  logic [4:0] first_vertex_i = '0;
  logic [4:0] middle_vertex_i = '0;
  logic [4:0] last_vertex_i = '0;
  logic       edge_value_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b1;
  logic       is_increasing_o;
  logic       is_decreasing_o;
  logic       found_o;
  logic [4:0] found_x_o;
  logic [4:0] found_v_o;
  logic [4:0] found_y_o;
  logic       index_error_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [5:0] cfg_vertex_count_i = '0;

  int  fail_count;
  int  pending;
  int  cycles = 0;
  bit  long_hold = 0;
  int  vertex_count_now = 32;

  always #5 clk_i = ~clk_i;

  graph_rotation_triple_search_top u_top (.*);

  graph_rotation_triple_search_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i(in_stall_o),
    .kind_i, .first_vertex_i, .middle_vertex_i, .last_vertex_i, .edge_value_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .is_increasing_i(is_increasing_o), .is_decreasing_i(is_decreasing_o),
    .found_i(found_o), .found_x_i(found_x_o), .found_v_i(found_v_o),
    .found_y_i(found_y_o), .index_error_i(index_error_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_vertex_count_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The watchdog counts every cycle and ends a run that has hung.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls on a pattern of its own, picked anew for each phase:
  // no stall at all, random stalls, or a regular duty cycle. When a long hold
  // is asked for it keeps the stall high over a hold that is counted here.
  initial begin
    int mode;
    int phase;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(3);
      for (phase = 0; phase < 64; phase++) begin
        @(negedge clk_i);
        if (long_hold) begin
          out_stall_i = 1'b1;
          repeat (400) @(negedge clk_i);
          long_hold = 0;
        end
        case (mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = ($urandom_range(1) == 0);
          2: out_stall_i = ($urandom_range(9) < 8);
          default: out_stall_i = (phase % 4) == 0;
        endcase
      end
    end
  end

  // Offers one transaction; it is entered at a falling edge and returns at the
  // falling edge after the block has taken it, with valid still high.
  task automatic send_item(input grts_pkg::kind_e kind, input int x, input int v,
                           input int y, input bit val);
    bit taken;
    kind_i = kind;
    first_vertex_i = x[4:0];
    middle_vertex_i = v[4:0];
    last_vertex_i = y[4:0];
    edge_value_i = val;
    in_valid_i = 1'b1;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    @(negedge clk_i);
  endtask

  // Bursts of random length separated by random gaps.
  int burst_left = 0;
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12);
      if ($urandom_range(1) == 1) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic void vertex_count_now_update(input int value);
    vertex_count_now = (value > 32) ? 32 : value;
  endfunction

  // The register is only written while no result is outstanding.
  task automatic set_vertex_count(input int value);
    bit taken;
    drain_results();
    cfg_vertex_count_i = value[5:0];
    cfg_valid_i = 1'b1;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = cfg_ready_o;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    vertex_count_now_update(value);
  endtask

  // A vertex index: mostly in range, occasionally anywhere in the field.
  function automatic int pick_vertex(input bit wild);
    if (wild || vertex_count_now == 0) return int'($urandom_range(31));
    return int'($urandom_range(vertex_count_now - 1));
  endfunction

  // One random transaction, shaped to build up edges so that tests and
  // searches see real structure: symmetric loads and rotations dominate.
  task automatic random_item(output int used);
    int  r;
    int  a;
    int  b;
    int  c;
    bit  wild;
    bit  val;
    wild = ($urandom_range(99) < 8);
    a = pick_vertex(wild);
    b = pick_vertex(wild);
    c = pick_vertex(wild);
    val = ($urandom_range(3) != 0);
    r = $urandom_range(99);
    used = 1;
    if (r < 42) begin
      send_item(grts_pkg::KIND_LOAD, a, b, c, val);
      if ($urandom_range(3) != 0) begin
        pace_sender();
        send_item(grts_pkg::KIND_LOAD, c, int'($urandom_range(31)), a, val);
        used = 2;
      end
    end else if (r < 62) begin
      send_item(grts_pkg::KIND_ROTATE, a, b, c, 1'($urandom_range(1)));
    end else if (r < 90 || (vertex_count_now > 16 && r < 95)) begin
      send_item(grts_pkg::KIND_TEST, a, b, c, 1'($urandom_range(1)));
    end else begin
      send_item(grts_pkg::KIND_SEARCH, int'($urandom_range(31)), int'($urandom_range(31)),
                int'($urandom_range(31)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int vcounts [10] = '{32, 2, 6, 0, 63, 1, 12, 32, 40, 8};
    int sent;
    int used;
    int per_phase;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset vertex count: empty search, extreme indices,
    // self loops, a rotation on overlapping vertices and the test outcomes.
    send_item(grts_pkg::KIND_SEARCH, 0, 0, 0, 1'b0);
    send_item(grts_pkg::KIND_LOAD, 0, 31, 31, 1'b1);
    send_item(grts_pkg::KIND_LOAD, 31, 0, 0, 1'b1);
    send_item(grts_pkg::KIND_LOAD, 5, 17, 5, 1'b1);
    send_item(grts_pkg::KIND_TEST, 0, 31, 5, 1'b0);
    send_item(grts_pkg::KIND_TEST, 31, 0, 5, 1'b0);
    send_item(grts_pkg::KIND_ROTATE, 3, 3, 3, 1'b0);
    send_item(grts_pkg::KIND_ROTATE, 0, 31, 7, 1'b1);
    send_item(grts_pkg::KIND_LOAD, 7, 0, 9, 1'b1);
    send_item(grts_pkg::KIND_LOAD, 7, 0, 10, 1'b1);
    send_item(grts_pkg::KIND_TEST, 7, 10, 31, 1'b0);
    send_item(grts_pkg::KIND_TEST, 31, 7, 30, 1'b0);
    send_item(grts_pkg::KIND_LOAD, 7, 0, 9, 1'b0);
    send_item(grts_pkg::KIND_SEARCH, 31, 31, 31, 1'b1);
    // A smaller graph: earlier entries in high columns drop out of the degrees,
    // and every kind of index error is tried.
    set_vertex_count(4);
    send_item(grts_pkg::KIND_LOAD, 4, 0, 0, 1'b1);
    send_item(grts_pkg::KIND_LOAD, 0, 0, 31, 1'b1);
    send_item(grts_pkg::KIND_ROTATE, 0, 4, 1, 1'b0);
    send_item(grts_pkg::KIND_TEST, 1, 2, 31, 1'b0);
    send_item(grts_pkg::KIND_LOAD, 0, 0, 1, 1'b1);
    send_item(grts_pkg::KIND_LOAD, 1, 0, 0, 1'b1);
    send_item(grts_pkg::KIND_SEARCH, 0, 0, 0, 1'b0);
    send_item(grts_pkg::KIND_TEST, 0, 1, 2, 1'b0);

    // Random part, one phase per vertex count.
    per_phase = RANDOM_ITEMS / 10;
    for (int p = 0; p < 10; p++) begin
      set_vertex_count(vcounts[p]);
      // Pressure: the receiver holds off while items keep coming back to back.
      if (p == 2) long_hold = 1;
      sent = 0;
      while (sent < per_phase) begin
        random_item(used);
        sent += used;
        if (!long_hold) pace_sender();
      end
      // Pressure: the sender stops until everything outstanding has returned.
      if (p == 5) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/grts_pkg.sv
hdl/graph_rotation_triple_search_top.sv
tb/graph_rotation_triple_search_checker.sv
tb/tb_top.sv
